>>> hw/rtl/sfl_pkg.sv
// Shared types and codes for the sorted free list slot table.
// Holds the request and response word formats, operation, status and slot kind codes.
// No dependencies.
`default_nettype none

package sfl_pkg;

  // Operation codes carried in the request word.
  localparam logic [2:0] FUNC_RELEASE = 3'd0;
  localparam logic [2:0] FUNC_CLAIM   = 3'd1;
  localparam logic [2:0] FUNC_NEXT    = 3'd2;
  localparam logic [2:0] FUNC_PREV    = 3'd3;
  localparam logic [2:0] FUNC_INIT    = 3'd4;

  // Status codes carried in the response word.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ALREADY = 3'd1;
  localparam logic [2:0] ST_UNINIT  = 3'd2;
  localparam logic [2:0] ST_NOFREE  = 3'd3;
  localparam logic [2:0] ST_BAD     = 3'd4;

  // Slot kinds as stored in the table.
  localparam logic [1:0] KIND_UNINIT = 2'd0;
  localparam logic [1:0] KIND_FREE   = 2'd1;
  localparam logic [1:0] KIND_USED   = 2'd2;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] index;
    logic [7:0] count;
  } sfl_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] neighbour;
    logic [7:0] free_slots;
    logic [7:0] lowest_free_slot;
    logic [7:0] highest_free_slot;
  } sfl_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/sorted_free_list_table.sv
// Sorted free list slot table: one operation in flight, one response word per request word.
// A release scans at most 2^INDEX_BITS-3 slots, one table read per scan cycle.
// The next request word is taken the cycle after the response is loaded into the output register.
// Reset (rst, synchronous) clears per-slot written bits so every slot reads as uninitialized
// with links of none at once; counters reset to zero and none. No clearing pass is needed.
`default_nettype none

module sorted_free_list_table #(
  parameter int INDEX_BITS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire sfl_pkg::sfl_req_t req,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output sfl_pkg::sfl_rsp_t     rsp
);

  import sfl_pkg::*;

  localparam int SLOTS = 1 << INDEX_BITS;
  localparam logic [INDEX_BITS-1:0] NONE_A = '1;
  localparam logic [INDEX_BITS-1:0] ONE_A  = INDEX_BITS'(1);
  localparam logic [INDEX_BITS-1:0] LAST_A = NONE_A - ONE_A;

  typedef struct packed {
    logic [1:0]            kind;
    logic [INDEX_BITS-1:0] prev;
    logic [INDEX_BITS-1:0] next;
  } slot_t;

  localparam slot_t SLOT_RESET = '{kind: KIND_UNINIT, prev: NONE_A, next: NONE_A};

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOOK = 4'd1;   // slot word of the request index arrives
  localparam logic [3:0] S_DN   = 4'd2;   // scan down for the nearest free slot
  localparam logic [3:0] S_UP   = 4'd3;   // scan up for the nearest free slot
  localparam logic [3:0] S_RIX  = 4'd4;   // release: write the slot itself
  localparam logic [3:0] S_RBL  = 4'd5;   // release: relink the lower neighbour
  localparam logic [3:0] S_RAB  = 4'd6;   // release: relink the upper neighbour
  localparam logic [3:0] S_C1   = 4'd7;   // claim: relink prev
  localparam logic [3:0] S_C2   = 4'd8;   // claim: relink next
  localparam logic [3:0] S_C3   = 4'd9;   // claim: mark the slot used
  localparam logic [3:0] S_INIT = 4'd10;  // init: write one slot per cycle
  localparam logic [3:0] S_DONE = 4'd11;  // load the response register

  // Slot table memory, one read port, one write port, registered read.
  slot_t                 mem [SLOTS];
  logic [SLOTS-1:0]      written;
  slot_t                 rd_q;
  logic                  rd_written;
  logic                  fwd_hit;
  slot_t                 fwd_word;
  slot_t                 rd_word;

  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_waddr;
  slot_t                 mem_wdata;
  logic [INDEX_BITS-1:0] mem_raddr;

  // Sequencer registers.
  logic [3:0]            state, state_next;
  logic [2:0]            func_r, func_r_next;
  logic [7:0]            index_r, index_r_next;
  logic [7:0]            count_r, count_r_next;
  logic [INDEX_BITS-1:0] sp, sp_next;
  logic [INDEX_BITS-1:0] p_r, p_r_next;
  logic [INDEX_BITS-1:0] n_r, n_r_next;
  logic [INDEX_BITS-1:0] below, below_next;
  logic [INDEX_BITS-1:0] above, above_next;
  slot_t                 below_word, below_word_next;
  slot_t                 above_word, above_word_next;
  logic [2:0]            status_r, status_r_next;
  logic [7:0]            nb_r, nb_r_next;
  logic [7:0]            free_total, free_total_next;
  logic [INDEX_BITS-1:0] lowest_free, lowest_free_next;
  logic [INDEX_BITS-1:0] highest_free, highest_free_next;

  logic                  rsp_load;
  logic                  req_ok_ix;
  logic                  req_ok_cnt;
  logic [INDEX_BITS-1:0] ix_a;
  logic [INDEX_BITS-1:0] cnt_a;
  logic [INDEX_BITS-1:0] link;

  // Index and count fit the table only when nonzero and below the none code.
  assign req_ok_ix  = (req.index != 8'd0) && (req.index < 8'(NONE_A));
  assign req_ok_cnt = (req.count != 8'd0) && (req.count < 8'(NONE_A));
  assign ix_a       = index_r[INDEX_BITS-1:0];
  assign cnt_a      = count_r[INDEX_BITS-1:0];

  assign req_stall  = (state != S_IDLE);
  assign rsp_load   = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  // Memory array and registered read; no reset on payload.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q     <= mem[mem_raddr];
    fwd_word <= mem_wdata;
  end

  // Written bits and forwarding flag: a slot never written reads as reset,
  // and a read issued in the cycle of a write to the same slot takes the new word.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
      fwd_hit    <= 1'b0;
    end else begin
      if (mem_we) begin
        written[mem_waddr] <= 1'b1;
      end
      rd_written <= written[mem_raddr];
      fwd_hit    <= mem_we && (mem_waddr == mem_raddr);
    end
  end

  assign rd_word = fwd_hit ? fwd_word : (rd_written ? rd_q : SLOT_RESET);

  // Query answer link.
  assign link = (func_r == FUNC_NEXT) ? rd_word.next : rd_word.prev;

  // Sequencer.
  always_comb begin
    state_next        = state;
    func_r_next       = func_r;
    index_r_next      = index_r;
    count_r_next      = count_r;
    sp_next           = sp;
    p_r_next          = p_r;
    n_r_next          = n_r;
    below_next        = below;
    above_next        = above;
    below_word_next   = below_word;
    above_word_next   = above_word;
    status_r_next     = status_r;
    nb_r_next         = nb_r;
    free_total_next   = free_total;
    lowest_free_next  = lowest_free;
    highest_free_next = highest_free;
    mem_we            = 1'b0;
    mem_waddr         = ix_a;
    mem_wdata         = rd_word;
    mem_raddr         = ix_a;

    unique case (state)
      S_IDLE: begin
        mem_raddr = req.index[INDEX_BITS-1:0];
        if (req_valid) begin
          func_r_next   = req.func;
          index_r_next  = req.index;
          count_r_next  = req.count;
          status_r_next = ST_BAD;
          nb_r_next     = 8'd0;
          if (req.func == FUNC_INIT) begin
            if (req_ok_cnt) begin
              sp_next    = ONE_A;
              state_next = S_INIT;
            end else begin
              state_next = S_DONE;
            end
          end else if ((req.func <= FUNC_PREV) && req_ok_ix) begin
            state_next = S_LOOK;
          end else begin
            state_next = S_DONE;
          end
        end
      end

      S_LOOK: begin
        priority if ((func_r == FUNC_NEXT) || (func_r == FUNC_PREV)) begin
          if (link == NONE_A) begin
            status_r_next = ST_NOFREE;
            nb_r_next     = index_r;
          end else begin
            status_r_next = ST_OK;
            nb_r_next     = 8'(link);
          end
          state_next = S_DONE;
        end else if (func_r == FUNC_RELEASE) begin
          below_next = NONE_A;
          above_next = NONE_A;
          if (rd_word.kind == KIND_FREE) begin
            status_r_next = ST_ALREADY;
            state_next    = S_DONE;
          end else if (rd_word.kind != KIND_USED) begin
            status_r_next = ST_UNINIT;
            state_next    = S_DONE;
          end else if (ix_a != ONE_A) begin
            mem_raddr  = ix_a - ONE_A;
            sp_next    = ix_a - ONE_A;
            state_next = S_DN;
          end else if (ix_a != LAST_A) begin
            mem_raddr  = ix_a + ONE_A;
            sp_next    = ix_a + ONE_A;
            state_next = S_UP;
          end else begin
            state_next = S_RIX;
          end
        end else begin
          // claim
          if (rd_word.kind == KIND_USED) begin
            status_r_next = ST_ALREADY;
            state_next    = S_DONE;
          end else if (rd_word.kind != KIND_FREE) begin
            status_r_next = ST_UNINIT;
            state_next    = S_DONE;
          end else begin
            p_r_next   = rd_word.prev;
            n_r_next   = rd_word.next;
            mem_raddr  = rd_word.prev;
            state_next = S_C1;
          end
        end
      end

      S_DN: begin
        // Data for sp arrives; the next lower address is issued meanwhile unless the scan ends.
        if ((rd_word.kind == KIND_FREE) || (sp == ONE_A)) begin
          if (rd_word.kind == KIND_FREE) begin
            below_next      = sp;
            below_word_next = rd_word;
          end
          if (ix_a != LAST_A) begin
            mem_raddr  = ix_a + ONE_A;
            sp_next    = ix_a + ONE_A;
            state_next = S_UP;
          end else begin
            state_next = S_RIX;
          end
        end else begin
          mem_raddr = sp - ONE_A;
          sp_next   = sp - ONE_A;
        end
      end

      S_UP: begin
        if (rd_word.kind == KIND_FREE) begin
          above_next      = sp;
          above_word_next = rd_word;
          state_next      = S_RIX;
        end else if (sp == LAST_A) begin
          state_next = S_RIX;
        end else begin
          mem_raddr = sp + ONE_A;
          sp_next   = sp + ONE_A;
        end
      end

      S_RIX: begin
        mem_we     = 1'b1;
        mem_waddr  = ix_a;
        mem_wdata  = '{kind: KIND_FREE, prev: below, next: above};
        state_next = S_RBL;
      end

      S_RBL: begin
        if (below != NONE_A) begin
          mem_we         = 1'b1;
          mem_waddr      = below;
          mem_wdata      = below_word;
          mem_wdata.next = ix_a;
        end else begin
          lowest_free_next = ix_a;
        end
        state_next = S_RAB;
      end

      S_RAB: begin
        if (above != NONE_A) begin
          mem_we         = 1'b1;
          mem_waddr      = above;
          mem_wdata      = above_word;
          mem_wdata.prev = ix_a;
        end else begin
          highest_free_next = ix_a;
        end
        if (free_total != 8'hFF) begin
          free_total_next = free_total + 8'd1;
        end
        status_r_next = ST_OK;
        state_next    = S_DONE;
      end

      S_C1: begin
        // Word of prev arrives; issue the read of next, forwarded if it is the same slot.
        if (p_r != NONE_A) begin
          mem_we         = 1'b1;
          mem_waddr      = p_r;
          mem_wdata      = rd_word;
          mem_wdata.next = n_r;
        end
        mem_raddr  = n_r;
        state_next = S_C2;
      end

      S_C2: begin
        if (n_r != NONE_A) begin
          mem_we         = 1'b1;
          mem_waddr      = n_r;
          mem_wdata      = rd_word;
          mem_wdata.prev = p_r;
        end
        mem_raddr  = ix_a;
        state_next = S_C3;
      end

      S_C3: begin
        mem_we         = 1'b1;
        mem_waddr      = ix_a;
        mem_wdata      = rd_word;
        mem_wdata.kind = KIND_USED;
        if (free_total != 8'd0) begin
          free_total_next = free_total - 8'd1;
        end
        if (ix_a == lowest_free) begin
          lowest_free_next = n_r;
        end
        if (ix_a == highest_free) begin
          highest_free_next = p_r;
        end
        status_r_next = ST_OK;
        state_next    = S_DONE;
      end

      S_INIT: begin
        mem_we         = 1'b1;
        mem_waddr      = sp;
        mem_wdata.kind = KIND_FREE;
        mem_wdata.prev = (sp == ONE_A) ? NONE_A : (sp - ONE_A);
        mem_wdata.next = (sp == cnt_a) ? NONE_A : (sp + ONE_A);
        if (sp == cnt_a) begin
          free_total_next   = count_r;
          lowest_free_next  = ONE_A;
          highest_free_next = cnt_a;
          status_r_next     = ST_OK;
          state_next        = S_DONE;
        end else begin
          sp_next = sp + ONE_A;
        end
      end

      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      free_total   <= 8'd0;
      lowest_free  <= NONE_A;
      highest_free <= NONE_A;
    end else begin
      state        <= state_next;
      free_total   <= free_total_next;
      lowest_free  <= lowest_free_next;
      highest_free <= highest_free_next;
    end
  end

  // Working registers of the current request; no reset needed.
  always_ff @(posedge clk) begin
    func_r     <= func_r_next;
    index_r    <= index_r_next;
    count_r    <= count_r_next;
    sp         <= sp_next;
    p_r        <= p_r_next;
    n_r        <= n_r_next;
    below      <= below_next;
    above      <= above_next;
    below_word <= below_word_next;
    above_word <= above_word_next;
    status_r   <= status_r_next;
    nb_r       <= nb_r_next;
  end

  // Output register: hold the response word until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status            <= status_r;
      rsp.neighbour         <= nb_r;
      rsp.free_slots        <= free_total;
      rsp.lowest_free_slot  <= 8'(lowest_free);
      rsp.highest_free_slot <= 8'(highest_free);
    end
  end

  // Scan pointer stays inside the valid slot range while scanning.
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DN) || (state == S_UP)) |-> ((sp != '0) && (sp != NONE_A)))
    else $error("scan pointer left the slot range");

  // The table is never written at slot zero or at the none code.
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((mem_waddr != '0) && (mem_waddr != NONE_A)))
    else $error("table write outside the slot range");

  // No table write while idle.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("table written while idle");

  // A response becomes valid only after the load state.
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_DONE))
    else $error("response loaded outside the load state");

endmodule

`default_nettype wire
